/* rtl/core/wmam_pkg.sv */
`timescale 1ns / 1ps

package wmam_pkg;

  // field widths
  localparam int unsigned COUNT_BITS  = 24;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned SUM_BITS    = COUNT_BITS + SAMPLE_BITS;
  localparam int unsigned TIME_BITS   = 64;
  localparam int unsigned WIN_BITS    = 40;
  localparam int unsigned STEP_BITS   = $clog2(SAMPLE_BITS);

  // window length used when the register holds zero, and its reset value
  localparam logic [WIN_BITS-1:0] WIN_DEFAULT_NS = WIN_BITS'(64'd600 * 64'd1000000000);

  // command codes
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // input word
  typedef struct packed {
    logic                   command;
    logic [SAMPLE_BITS-1:0] vrms_sample;
    logic [TIME_BITS-1:0]   time_ns;
  } wmam_in_t;

  // output word: one closed window
  typedef struct packed {
    logic [TIME_BITS-1:0]   window_start;
    logic [TIME_BITS-1:0]   window_end;
    logic [COUNT_BITS-1:0]  sample_count;
    logic [SAMPLE_BITS-1:0] minimum_value;
    logic [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-1:0] maximum_value;
  } wmam_out_t;

endpackage

/* rtl/core/windowed_min_avg_max_rollup.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    in_data_i   (wmam_pkg::wmam_in_t)
// out       output     out_valid_o / out_ready_i  out_data_o  (wmam_pkg::wmam_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i  (window length, ns)
//
// A word that closes no window goes through the diff and decide states to idle.
// A word that closes a window also goes through divider init, the 16 steps of the
// restoring divider (mean) and the push, which waits for the output register.
// Reset clears the window (empty) and sets the window length to 600 s.
// in_ready_o is low while a word is at work; out_data_o holds until taken.
module windowed_min_avg_max_rollup (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  wmam_pkg::wmam_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output wmam_pkg::wmam_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wmam_pkg::WIN_BITS-1:0]   cfg_data_i
);

  localparam int unsigned CB = wmam_pkg::COUNT_BITS;
  localparam int unsigned SB = wmam_pkg::SAMPLE_BITS;
  localparam int unsigned UB = wmam_pkg::SUM_BITS;
  localparam int unsigned TB = wmam_pkg::TIME_BITS;
  localparam int unsigned WB = wmam_pkg::WIN_BITS;
  localparam int unsigned KB = wmam_pkg::STEP_BITS;
  localparam logic [KB-1:0] LAST_STEP = KB'(SB - 1);
  localparam logic [CB-1:0] COUNT_MAX = {CB{1'b1}};

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DIFF   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_DINIT  = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_PUSH   = 6'b100000
  } wmam_state_e;

  wmam_state_e state_q, state_d;

  // window state
  logic [WB-1:0] win_q;
  logic [TB-1:0] start_q, start_d;
  logic [SB-1:0] min_q, min_d;
  logic [SB-1:0] max_q, max_d;
  logic [UB-1:0] sum_q, sum_d;
  logic [CB-1:0] cnt_q, cnt_d;

  // latched input word
  logic          cmd_q;
  logic [SB-1:0] smp_q;
  logic [TB-1:0] time_q;

  // window age check
  logic [TB-1:0] diff_q, diff_d;
  logic          borrow_q, borrow_d;

  // divider
  logic [CB-1:0] rem_q, rem_d;
  logic [SB-1:0] quo_q, quo_d;
  logic [KB-1:0] step_q, step_d;

  // output register
  logic                out_valid_q, out_valid_d;
  wmam_pkg::wmam_out_t out_q, out_d;

  logic          accept;
  logic [WB-1:0] win_eff;
  logic          emit;
  logic [UB-1:0] dividend;
  logic [CB:0]   trial;
  logic          out_free;
  logic [SB-1:0] min_upd, max_upd;
  logic          empty;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign empty       = (cnt_q == '0);

  // zero length stands for the default window
  assign win_eff  = (win_q == '0) ? wmam_pkg::WIN_DEFAULT_NS : win_q;

  // a flush closes any non-empty window, a sample closes an aged one
  assign emit     = !empty && ((cmd_q == wmam_pkg::CMD_FLUSH) ||
                    (!borrow_q && (diff_q >= TB'(win_eff))));

  // rounded-half-up dividend and one restoring step
  assign dividend = sum_q + UB'(cnt_q >> 1);
  assign trial    = {rem_q, quo_q[SB-1]} - {1'b0, cnt_q};

  // running min and max for an added sample, the empty window opening on it
  assign min_upd  = (empty || (smp_q < min_q)) ? smp_q : min_q;
  assign max_upd  = (empty || (smp_q > max_q)) ? smp_q : max_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    start_d     = start_q;
    min_d       = min_q;
    max_d       = max_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    diff_d      = diff_q;
    borrow_d    = borrow_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    step_d      = step_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        {borrow_d, diff_d} = {1'b0, time_q} - {1'b0, start_q};
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (emit) begin
          state_d = ST_DINIT;
        end else begin
          if (cmd_q == wmam_pkg::CMD_ADD) begin
            if (empty) begin
              start_d = time_q;
            end
            min_d = min_upd;
            max_d = max_upd;
            if (cnt_q != COUNT_MAX) begin
              sum_d = sum_q + UB'(smp_q);
              cnt_d = cnt_q + 1'b1;
            end
          end
          state_d = ST_IDLE;
        end
      end
      ST_DINIT: begin
        rem_d   = dividend[UB-1:SB];
        quo_d   = dividend[SB-1:0];
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!trial[CB]) begin
          rem_d = trial[CB-1:0];
        end else begin
          rem_d = {rem_q[CB-2:0], quo_q[SB-1]};
        end
        quo_d  = {quo_q[SB-2:0], !trial[CB]};
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.window_start  = start_q;
          out_d.window_end    = time_q;
          out_d.sample_count  = cnt_q;
          out_d.minimum_value = min_q;
          out_d.mean_value    = quo_q;
          out_d.maximum_value = max_q;
          // open the next window at the closing time
          start_d = time_q;
          if (cmd_q == wmam_pkg::CMD_FLUSH) begin
            min_d = '0;
            max_d = '0;
            sum_d = '0;
            cnt_d = '0;
          end else begin
            min_d = smp_q;
            max_d = smp_q;
            sum_d = UB'(smp_q);
            cnt_d = CB'(1);
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      win_q       <= wmam_pkg::WIN_DEFAULT_NS;
      start_q     <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        win_q <= cfg_data_i;
      end
      start_q     <= start_d;
      min_q       <= min_d;
      max_q       <= max_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_data_i.command;
      smp_q  <= in_data_i.vrms_sample;
      time_q <= in_data_i.time_ns;
    end
    diff_q   <= diff_d;
    borrow_q <= borrow_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

  // a non-empty window never has min above max
  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (min_q <= max_q))
    else $error("window min above max");

  // divider remainder stays below the divisor
  a_rem_lt_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cnt_q))
    else $error("divider remainder out of range");

  // last divider step hands over to the push
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DIV) && (step_q == LAST_STEP)) |=> (state_q == ST_PUSH))
    else $error("divider overran its step count");

  // a record only appears out of the push state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_PUSH))
    else $error("output word loaded outside push");

endmodule

/* test/windowed_min_avg_max_rollup_test.sv */
`timescale 1ns / 1ps

module windowed_min_avg_max_rollup_test;

  // cycles a word that emits nothing may still need after the last record
  localparam int unsigned SETTLE_CYCLES = 24;

  typedef enum logic {ROW_WORD, ROW_LENGTH} row_kind_e;

  typedef struct packed {
    row_kind_e                     kind;
    logic                          typed;
    wmam_pkg::wmam_in_t            word;
    logic [wmam_pkg::WIN_BITS-1:0] length;
    wmam_pkg::wmam_out_t           want;
  } dir_row_t;

  logic                          clk_i = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  wmam_pkg::wmam_in_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  wmam_pkg::wmam_out_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [wmam_pkg::WIN_BITS-1:0] cfg_data = '0;

  // window state mirror
  logic [wmam_pkg::WIN_BITS-1:0]    window_len = wmam_pkg::WIN_DEFAULT_NS;
  logic [wmam_pkg::TIME_BITS-1:0]   win_start = '0;
  logic [wmam_pkg::SAMPLE_BITS-1:0] win_min = '0;
  logic [wmam_pkg::SAMPLE_BITS-1:0] win_max = '0;
  logic [wmam_pkg::SUM_BITS-1:0]    win_sum = '0;
  logic [wmam_pkg::COUNT_BITS-1:0]  win_count = '0;

  wmam_pkg::wmam_out_t expected_windows[$];
  dir_row_t            dir_rows[$];
  wmam_pkg::wmam_out_t head;
  int unsigned         errors = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         recv_stall_pct = 0;
  int unsigned         hold_left = 0;
  logic [63:0]         clock_ns = '0;

  windowed_min_avg_max_rollup dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("windowed_min_avg_max_rollup: mismatch");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] span_ns();
    return (window_len == '0) ? 64'(wmam_pkg::WIN_DEFAULT_NS) : 64'(window_len);
  endfunction

  // record of the open window, closed at end_t
  function automatic wmam_pkg::wmam_out_t window_record(input logic [63:0] end_t);
    wmam_pkg::wmam_out_t rec;
    logic [63:0]         mean;
    mean = (64'(win_sum) + 64'(win_count >> 1)) / 64'(win_count);
    rec.window_start  = win_start;
    rec.window_end    = end_t;
    rec.sample_count  = win_count;
    rec.minimum_value = win_min;
    rec.mean_value    = mean[wmam_pkg::SAMPLE_BITS-1:0];
    rec.maximum_value = win_max;
    return rec;
  endfunction

  function automatic void reopen(input logic [63:0] t,
                                 input logic [wmam_pkg::SAMPLE_BITS-1:0] v);
    win_start = t;
    win_min   = v;
    win_max   = v;
    win_sum   = '0;
    win_count = '0;
  endfunction

  // advance the window mirror by one word, returns 1 when a window closes
  function automatic bit roll_window(input wmam_pkg::wmam_in_t w,
                                     output wmam_pkg::wmam_out_t rec);
    bit closed;
    closed = 1'b0;
    rec = '0;
    if (w.command == wmam_pkg::CMD_FLUSH) begin
      if (win_count == '0) return 1'b0;
      rec = window_record(w.time_ns);
      reopen(w.time_ns, '0);
      return 1'b1;
    end
    if (win_count == '0) reopen(w.time_ns, w.vrms_sample);
    // exact: the difference is only taken when time is not before start
    if (w.time_ns >= win_start && (w.time_ns - win_start) >= span_ns()) begin
      rec = window_record(w.time_ns);
      closed = 1'b1;
      reopen(w.time_ns, w.vrms_sample);
    end
    if (w.vrms_sample < win_min) win_min = w.vrms_sample;
    if (w.vrms_sample > win_max) win_max = w.vrms_sample;
    if (win_count != '1) begin
      win_sum   = win_sum + wmam_pkg::SUM_BITS'(w.vrms_sample);
      win_count = win_count + 1'b1;
    end
    return closed;
  endfunction

  // mostly steps inside the window, some jumps past it, some back in time
  function automatic wmam_pkg::wmam_in_t random_word();
    wmam_pkg::wmam_in_t w;
    int unsigned        roll;
    int unsigned        pick;
    logic [63:0]        span;
    span = span_ns();
    roll = $urandom_range(99);
    pick = $urandom_range(9);
    w.command     = (roll < 8) ? wmam_pkg::CMD_FLUSH : wmam_pkg::CMD_ADD;
    w.vrms_sample = (pick == 0) ? '0 : (pick == 1) ? '1 :
                    wmam_pkg::SAMPLE_BITS'($urandom);
    if (roll < 70) clock_ns = clock_ns + rand64() % (span / 4 + 64'd1);
    else if (roll < 85) clock_ns = clock_ns + span + rand64() % (span / 8 + 64'd1);
    else if (roll < 93) clock_ns = clock_ns - rand64() % (span + 64'd1);
    else clock_ns = rand64();
    w.time_ns = clock_ns;
    return w;
  endfunction

  function automatic dir_row_t word_row(input logic cmd, input logic [15:0] v,
                                        input logic [63:0] t);
    dir_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.word = '{command: cmd, vrms_sample: v, time_ns: t};
    return r;
  endfunction

  function automatic dir_row_t length_row(input logic [wmam_pkg::WIN_BITS-1:0] len);
    dir_row_t r;
    r = '0;
    r.kind   = ROW_LENGTH;
    r.length = len;
    return r;
  endfunction

  function automatic dir_row_t known_row(input logic cmd, input logic [15:0] v,
                                         input logic [63:0] t, input logic [63:0] s,
                                         input logic [23:0] n, input logic [15:0] mn,
                                         input logic [15:0] avg, input logic [15:0] mx);
    dir_row_t r;
    r = word_row(cmd, v, t);
    r.typed = 1'b1;
    r.want  = '{window_start: s, window_end: t, sample_count: n,
                minimum_value: mn, mean_value: avg, maximum_value: mx};
    return r;
  endfunction

  // present one word and hold it until taken; entered and left at a falling edge
  task automatic offer_word(input wmam_pkg::wmam_in_t w, input logic typed,
                            input wmam_pkg::wmam_out_t want);
    wmam_pkg::wmam_out_t rec;
    bit                  closed;
    closed = roll_window(w, rec);
    if (typed) expected_windows.push_back(want);
    else if (closed) expected_windows.push_back(rec);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  // all records taken, then room for a word that emits nothing to finish
  task automatic wait_idle();
    while (expected_windows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_window_length(input logic [wmam_pkg::WIN_BITS-1:0] len);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data  = len;
    do @(posedge clk_i); while (!cfg_ready);
    window_len = len;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // receiver: long hold-off when asked, else random stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s: expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each taken record with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_windows.size() == 0) begin
        $display("%0t unexpected record: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        head = expected_windows.pop_front();
        check_field("window_start", head.window_start, out_data.window_start);
        check_field("window_end", head.window_end, out_data.window_end);
        check_field("sample_count", 64'(head.sample_count), 64'(out_data.sample_count));
        check_field("minimum_value", 64'(head.minimum_value), 64'(out_data.minimum_value));
        check_field("mean_value", 64'(head.mean_value), 64'(out_data.mean_value));
        check_field("maximum_value", 64'(head.maximum_value), 64'(out_data.maximum_value));
      end
    end
  end

  initial begin
    dir_row_t                      r;
    int unsigned                   phase_send[4];
    int unsigned                   phase_recv[4];
    logic [wmam_pkg::WIN_BITS-1:0] phase_len[4];

    phase_send = '{0, 54, 0, 32};
    phase_recv = '{0, 0, 54, 32};
    phase_len  = '{40'd1, 40'd0, '1, 40'd37};

    // default length after reset, extremes, late and early times, flushes
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd0, 64'd0));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'hFFFF, 64'd100));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd1, 64'd599_999_999_999));
    dir_rows.push_back(known_row(wmam_pkg::CMD_ADD, 16'd500, 64'd600_000_000_000,
                                 64'd0, 24'd3, 16'd0, 16'd21845, 16'hFFFF));
    dir_rows.push_back(known_row(wmam_pkg::CMD_FLUSH, 16'd0, 64'd600_000_000_005,
                                 64'd600_000_000_000, 24'd1, 16'd500, 16'd500, 16'd500));
    // flush of an empty window
    dir_rows.push_back(word_row(wmam_pkg::CMD_FLUSH, 16'hFFFF, 64'd7));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd10, 64'd1000));
    // time before the window start never closes it
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd20, 64'd5));
    dir_rows.push_back(length_row(40'd1));
    dir_rows.push_back(known_row(wmam_pkg::CMD_ADD, 16'd30, 64'd1001,
                                 64'd1000, 24'd2, 16'd10, 16'd15, 16'd20));
    // zero length acts as the default
    dir_rows.push_back(length_row(40'd0));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd40, 64'd600_000_001_000));
    dir_rows.push_back(known_row(wmam_pkg::CMD_ADD, 16'd50, 64'd600_000_001_001,
                                 64'd1001, 24'd2, 16'd30, 16'd35, 16'd40));
    // window end past the top of the time range
    dir_rows.push_back(length_row('1));
    dir_rows.push_back(known_row(wmam_pkg::CMD_FLUSH, 16'd0, 64'hFFFF_FFFF_FFFF_FFF0,
                                 64'd600_000_001_001, 24'd1, 16'd50, 16'd50, 16'd50));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FF00));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF));
    dir_rows.push_back(known_row(wmam_pkg::CMD_FLUSH, 16'd0, 64'd0,
                                 64'hFFFF_FFFF_FFFF_FF00, 24'd2, 16'd0, 16'd32768,
                                 16'hFFFF));
    // mean rounds half up
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd1, 64'd10));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd2, 64'd11));
    dir_rows.push_back(known_row(wmam_pkg::CMD_FLUSH, 16'hFFFF, 64'd12,
                                 64'd10, 24'd2, 16'd1, 16'd2, 16'd2));
    // shortest window
    dir_rows.push_back(length_row(40'd1));
    dir_rows.push_back(word_row(wmam_pkg::CMD_ADD, 16'd7, 64'd20));
    dir_rows.push_back(known_row(wmam_pkg::CMD_ADD, 16'd8, 64'd21,
                                 64'd20, 24'd1, 16'd7, 16'd7, 16'd7));

    repeat (11) @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.kind == ROW_LENGTH) write_window_length(r.length);
      else offer_word(r.word, r.typed, r.want);
    end

    // random phases, each with its own window length and idling
    for (int p = 0; p < 4; p++) begin
      write_window_length(phase_len[p]);
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      if (p == 0) hold_left = 400;
      if (p == 2) clock_ns = 64'hFFFF_FF00_0000_0000 | 64'(rand64() >> 24);
      repeat (112) offer_word(random_word(), 1'b0, '0);
    end

    wait_idle();
    if (errors == 0) $display("windowed_min_avg_max_rollup: match");
    else $display("windowed_min_avg_max_rollup: mismatch");
    $finish;
  end

endmodule
